// ===== rtl/lptc_pkg.sv =====
`default_nettype none

package lptc_pkg;

    localparam int NSEG = 5;
    localparam int SEG_BITS = 3;
    localparam int IDX_BITS = 3;
    localparam int LEN_BITS = 4;

    localparam logic [SEG_BITS-1:0] SEG_OPEN1 = 3'd0;
    localparam logic [SEG_BITS-1:0] SEG_HELD  = 3'd1;
    localparam logic [SEG_BITS-1:0] SEG_SNIP  = 3'd2;
    localparam logic [SEG_BITS-1:0] SEG_OPEN2 = 3'd3;
    localparam logic [SEG_BITS-1:0] SEG_CHAR  = 3'd4;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_BITS = $clog2(QUEUE_DEPTH);

    localparam int CFG_DATA_BITS = 32;
    localparam int CFG_ADDR_BITS = 3;
    localparam logic REG_MAX_LINE_LEN = 1'b0;
    localparam logic [15:0] MAX_LINE_LEN_RESET = 16'd200;

    localparam logic REQ_BYTE = 1'b0;
    localparam logic REQ_END  = 1'b1;

    localparam logic [7:0] CH_LF  = 8'h0A;
    localparam logic [7:0] CH_CR  = 8'h0D;
    localparam logic [7:0] CH_EQ  = 8'h3D;
    localparam logic [7:0] CH_GT  = 8'h3E;
    localparam logic [7:0] CH_QM  = 8'h3F;
    localparam logic [7:0] CH_LBR = 8'h5B;
    localparam logic [7:0] CH_RBR = 8'h5D;

    typedef enum logic [3:0] {
        S_OPEN    = 4'd0,
        S_TAG     = 4'd1,
        S_QM      = 4'd2,
        S_ESC     = 4'd3,
        S_CLOSE   = 4'd4,
        S_NLCLOSE = 4'd5,
        S_WEXP    = 4'd6,
        S_EEXP    = 4'd7,
        S_NL      = 4'd8,
        S_CHAR    = 4'd9
    } sid_t;

    localparam logic [LEN_BITS-1:0] LEN_OPEN    = 4'd5;
    localparam logic [LEN_BITS-1:0] LEN_ESC     = 4'd8;
    localparam logic [LEN_BITS-1:0] LEN_CLOSE   = 4'd3;
    localparam logic [LEN_BITS-1:0] LEN_NLCLOSE = 4'd4;
    localparam logic [LEN_BITS-1:0] LEN_WEXP    = 4'd3;
    localparam logic [LEN_BITS-1:0] LEN_EEXP    = 4'd2;
    localparam logic [LEN_BITS-1:0] LEN_ONE     = 4'd1;
    localparam logic [LEN_BITS-1:0] LEN_NONE    = 4'd0;

    // strings left-aligned in eight bytes
    localparam logic [63:0] STR_OPEN    = {"_w[[\n", 24'h0};
    localparam logic [63:0] STR_TAG     = {"<?lua", 24'h0};
    localparam logic [63:0] STR_QM      = {"?", 56'h0};
    localparam logic [63:0] STR_ESC     = "]\n_w']'\n";
    localparam logic [63:0] STR_CLOSE   = {"]]\n", 40'h0};
    localparam logic [63:0] STR_NLCLOSE = {"\n]]\n", 32'h0};
    localparam logic [63:0] STR_WEXP    = {"_w(", 40'h0};
    localparam logic [63:0] STR_EEXP    = {")\n", 48'h0};
    localparam logic [63:0] STR_NL      = {"\n", 56'h0};

    typedef struct packed {
        sid_t                sid;
        logic [LEN_BITS-1:0] len;
    } seg_t;

    typedef struct packed {
        seg_t [NSEG-1:0] seg;
        logic [7:0]      ch;
    } cmd_t;

    function automatic logic [63:0] str_word(sid_t sid);
        logic [63:0] w;
        unique case (sid)
            S_OPEN:    w = STR_OPEN;
            S_TAG:     w = STR_TAG;
            S_QM:      w = STR_QM;
            S_ESC:     w = STR_ESC;
            S_CLOSE:   w = STR_CLOSE;
            S_NLCLOSE: w = STR_NLCLOSE;
            S_WEXP:    w = STR_WEXP;
            S_EEXP:    w = STR_EEXP;
            S_NL:      w = STR_NL;
            default:   w = 64'h0;
        endcase
        return w;
    endfunction

    function automatic logic [7:0] str_byte(sid_t sid, logic [IDX_BITS-1:0] idx);
        logic [63:0] w;
        logic [5:0]  pos;
        w = str_word(sid);
        pos = {3'd7 - idx, 3'b000};
        return w[pos +: 8];
    endfunction

endpackage

`default_nettype wire

// ===== rtl/lptc_in_if.sv =====
`default_nettype none

interface lptc_in_if;
    logic       valid;
    logic       ready;
    logic       req_type;
    logic [7:0] in_byte;

    modport source (output valid, output req_type, output in_byte, input ready);
    modport sink (input valid, input req_type, input in_byte, output ready);
endinterface

`default_nettype wire

// ===== rtl/lptc_out_if.sv =====
`default_nettype none

interface lptc_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       out_last;

    modport source (output valid, output out_byte, output out_last, input ready);
    modport sink (input valid, input out_byte, input out_last, output ready);
endinterface

`default_nettype wire

// ===== rtl/lptc_front.sv =====
`default_nettype none

module lptc_front #(
    parameter int LINE_COUNT_BITS = 16
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    lptc_in_if.sink             page,
    input  wire logic [15:0]    max_line_len,
    output lptc_pkg::cmd_t      cmd,
    output logic                push,
    input  wire logic           full
);
    import lptc_pkg::*;

    localparam int LCB = LINE_COUNT_BITS;
    localparam int CW = ((LCB > 16) ? LCB : 16) + 1;
    localparam logic [LCB-1:0] LC_MAX = {LCB{1'b1}};

    typedef enum logic [3:0] {
        M_TEXT = 4'b0001,
        M_TAG  = 4'b0010,
        M_STMT = 4'b0100,
        M_EXPR = 4'b1000
    } mode_t;

    mode_t          mode_reg, mode_next;
    logic [2:0]     op_reg, op_next;
    logic           cp_reg, cp_next;
    logic [LCB-1:0] lc_reg, lc_next;
    logic [7:0]     prev_reg, prev_next;

    logic [7:0]     c;
    logic [LCB-1:0] lc_a;
    logic [LCB-1:0] lc_b;
    logic [LCB:0]   lc_sum;
    logic           emit;
    logic           any_out;

    assign c = page.in_byte;
    assign page.ready = !full;

    always_comb
    begin
        mode_next = mode_reg;
        op_next = op_reg;
        cp_next = cp_reg;
        lc_next = lc_reg;
        prev_next = prev_reg;
        lc_a = lc_reg;
        lc_b = lc_reg;
        lc_sum = '0;
        emit = 1'b0;
        for (int k = 0; k < NSEG; k++)
        begin
            cmd.seg[k].sid = S_OPEN;
            cmd.seg[k].len = LEN_NONE;
        end
        cmd.seg[SEG_HELD].sid = S_TAG;
        cmd.seg[SEG_CHAR].sid = S_CHAR;
        cmd.ch = c;

        if (page.req_type == REQ_END)
        begin
            if (mode_reg == M_TEXT && lc_reg != '0)
            begin
                cmd.seg[SEG_SNIP].sid = S_CLOSE;
                cmd.seg[SEG_SNIP].len = LEN_CLOSE;
            end
            mode_next = M_TEXT;
            op_next = 3'd0;
            cp_next = 1'b0;
            lc_next = '0;
            prev_next = 8'h00;
        end
        else
        begin
            prev_next = c;
            if (mode_reg == M_TEXT && c == str_byte(S_TAG, op_reg))
            begin
                if (op_reg == 3'd4)
                begin
                    mode_next = M_TAG;
                    op_next = 3'd0;
                    cp_next = 1'b0;
                    if (lc_reg != '0)
                    begin
                        cmd.seg[SEG_SNIP].sid = S_CLOSE;
                        cmd.seg[SEG_SNIP].len = LEN_CLOSE;
                    end
                    lc_next = '0;
                end
                else
                begin
                    op_next = op_reg + 3'd1;
                end
            end
            else if (mode_reg == M_TAG && !cp_reg && c == CH_EQ)
            begin
                mode_next = M_EXPR;
                op_next = 3'd0;
                cp_next = 1'b0;
                cmd.seg[SEG_SNIP].sid = S_WEXP;
                cmd.seg[SEG_SNIP].len = LEN_WEXP;
            end
            else if (mode_reg != M_TEXT && c == (cp_reg ? CH_GT : CH_QM))
            begin
                if (cp_reg)
                begin
                    if (mode_reg == M_EXPR)
                    begin
                        cmd.seg[SEG_SNIP].sid = S_EEXP;
                        cmd.seg[SEG_SNIP].len = LEN_EEXP;
                    end
                    else
                    begin
                        cmd.seg[SEG_SNIP].sid = S_NL;
                        cmd.seg[SEG_SNIP].len = LEN_ONE;
                    end
                    mode_next = M_TEXT;
                    op_next = 3'd0;
                    cp_next = 1'b0;
                end
                else
                begin
                    cp_next = 1'b1;
                end
            end
            else
            begin
                if (mode_reg == M_TAG)
                begin
                    mode_next = M_STMT;
                end
                op_next = 3'd0;
                cp_next = 1'b0;
                if (mode_reg == M_TEXT)
                begin
                    // replay held tag bytes
                    if (op_reg != 3'd0)
                    begin
                        if (lc_reg == '0)
                        begin
                            cmd.seg[SEG_OPEN1].len = LEN_OPEN;
                        end
                        cmd.seg[SEG_HELD].len = {1'b0, op_reg};
                        lc_sum = {1'b0, lc_reg} + {{(LCB-2){1'b0}}, op_reg};
                        lc_a = lc_sum[LCB] ? LC_MAX : lc_sum[LCB-1:0];
                    end
                    lc_b = lc_a;
                    emit = 1'b1;
                    if (c == CH_RBR && prev_reg == CH_RBR)
                    begin
                        cmd.seg[SEG_SNIP].sid = S_ESC;
                        cmd.seg[SEG_SNIP].len = LEN_ESC;
                        lc_b = '0;
                    end
                    else if (c == CH_LBR && prev_reg == CH_LBR)
                    begin
                        cmd.seg[SEG_SNIP].sid = S_CLOSE;
                        cmd.seg[SEG_SNIP].len = LEN_CLOSE;
                        lc_b = '0;
                    end
                    else if (c == CH_LF)
                    begin
                        if ({{(CW-LCB){1'b0}}, lc_a} > {{(CW-16){1'b0}}, max_line_len})
                        begin
                            cmd.seg[SEG_SNIP].sid = S_NLCLOSE;
                            cmd.seg[SEG_SNIP].len = LEN_NLCLOSE;
                            lc_b = '0;
                        end
                    end
                    else if (c == CH_CR)
                    begin
                        emit = 1'b0;
                    end
                    if (emit)
                    begin
                        if (lc_b == '0)
                        begin
                            cmd.seg[SEG_OPEN2].len = LEN_OPEN;
                        end
                        cmd.seg[SEG_CHAR].len = LEN_ONE;
                        lc_next = (lc_b == LC_MAX) ? lc_b : lc_b + 1'b1;
                    end
                    else
                    begin
                        lc_next = lc_a;
                    end
                end
                else
                begin
                    if (cp_reg)
                    begin
                        cmd.seg[SEG_HELD].sid = S_QM;
                        cmd.seg[SEG_HELD].len = LEN_ONE;
                    end
                    cmd.seg[SEG_CHAR].len = LEN_ONE;
                end
            end
        end

        any_out = 1'b0;
        for (int k = 0; k < NSEG; k++)
        begin
            any_out = any_out | (cmd.seg[k].len != LEN_NONE);
        end
        push = page.valid && page.ready && any_out;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= M_TEXT;
            op_reg <= 3'd0;
            cp_reg <= 1'b0;
            lc_reg <= '0;
            prev_reg <= 8'h00;
        end
        else if (page.valid && page.ready)
        begin
            mode_reg <= mode_next;
            op_reg <= op_next;
            cp_reg <= cp_next;
            lc_reg <= lc_next;
            prev_reg <= prev_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/lptc_queue.sv =====
`default_nettype none

module lptc_queue (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push,
    input  wire lptc_pkg::cmd_t wr_data,
    output logic                full,
    input  wire logic           pop,
    output lptc_pkg::cmd_t      rd_data,
    output logic                empty
);
    import lptc_pkg::*;

    cmd_t                 mem_reg [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0] wr_ptr_reg;
    logic [QPTR_BITS-1:0] rd_ptr_reg;
    logic [QPTR_BITS:0]   count_reg;

    assign full = (count_reg == QUEUE_DEPTH[QPTR_BITS:0]);
    assign empty = (count_reg == '0);
    assign rd_data = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push && !full)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (push && !full)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop && !empty)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if ((push && !full) && !(pop && !empty))
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (!(push && !full) && (pop && !empty))
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/lptc_back.sv =====
`default_nettype none

module lptc_back (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire lptc_pkg::cmd_t head,
    input  wire logic           empty,
    output logic                pop,
    lptc_out_if.source          script
);
    import lptc_pkg::*;

    // lowest non-empty segment at or after the given one
    function automatic logic [SEG_BITS:0] find_seg(cmd_t cm, logic [SEG_BITS-1:0] from);
        logic [SEG_BITS:0] r;
        r = '0;
        for (int k = NSEG - 1; k >= 0; k--)
        begin
            if (SEG_BITS'(k) >= from && cm.seg[k].len != LEN_NONE)
            begin
                r = {1'b1, SEG_BITS'(k)};
            end
        end
        return r;
    endfunction

    cmd_t                cmd_reg;
    logic                busy_reg;
    logic [SEG_BITS-1:0] seg_reg;
    logic [IDX_BITS-1:0] idx_reg;
    logic                ov_reg;
    logic [7:0]          byte_reg;
    logic                last_reg;

    seg_t              cur;
    logic [7:0]        cur_byte;
    logic              at_seg_end;
    logic [SEG_BITS:0] nxt;
    logic [SEG_BITS:0] first;
    logic              is_last;
    logic              advance;

    always_comb
    begin
        cur = cmd_reg.seg[seg_reg];
        cur_byte = (cur.sid == S_CHAR) ? cmd_reg.ch : str_byte(cur.sid, idx_reg);
        at_seg_end = (({1'b0, idx_reg} + 4'd1) == cur.len);
        nxt = find_seg(cmd_reg, seg_reg + 1'b1);
        is_last = at_seg_end && !nxt[SEG_BITS];
        advance = busy_reg && (!ov_reg || script.ready);
        first = find_seg(head, '0);
        pop = !empty && (!busy_reg || (advance && is_last));
    end

    assign script.valid = ov_reg;
    assign script.out_byte = byte_reg;
    assign script.out_last = last_reg;

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            byte_reg <= cur_byte;
            last_reg <= is_last;
        end
        if (pop)
        begin
            cmd_reg <= head;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            seg_reg <= '0;
            idx_reg <= '0;
            ov_reg <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                ov_reg <= 1'b1;
            end
            else if (script.ready)
            begin
                ov_reg <= 1'b0;
            end
            if (pop)
            begin
                busy_reg <= 1'b1;
                seg_reg <= first[SEG_BITS-1:0];
                idx_reg <= '0;
            end
            else if (advance)
            begin
                if (at_seg_end)
                begin
                    seg_reg <= nxt[SEG_BITS-1:0];
                    idx_reg <= '0;
                end
                else
                begin
                    idx_reg <= idx_reg + 1'b1;
                end
                if (is_last)
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/lua_page_template_converter.sv =====
// a request's first byte passes the command queue, command register and output register, after queued work
// throughput: one request a cycle if the 4-entry command queue has room; one script byte a cycle if ready
// a request makes 0 to 19 script bytes, put out one by one by the byte sequencer
// reset (rst_n low, asynchronous): text mode, no held tag bytes, line count zero, queue empty
// max_line_len returns to 200 on reset and is kept across end-of-page requests
`default_nettype none

module lua_page_template_converter #(
    parameter int LINE_COUNT_BITS = 16
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    lptc_in_if.sink                                  page,
    lptc_out_if.source                               script,
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [lptc_pkg::CFG_ADDR_BITS-1:0]  paddr,
    input  wire logic [lptc_pkg::CFG_DATA_BITS-1:0]  pwdata,
    output logic [lptc_pkg::CFG_DATA_BITS-1:0]       prdata,
    output logic                                     pready
);
    import lptc_pkg::*;

    logic [15:0] max_line_len_reg;
    cmd_t        push_cmd;
    cmd_t        head_cmd;
    logic        push;
    logic        full;
    logic        pop;
    logic        empty;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_MAX_LINE_LEN) ? {16'h0000, max_line_len_reg} : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_line_len_reg <= MAX_LINE_LEN_RESET;
        end
        else if (psel && penable && pwrite && pready && paddr[2] == REG_MAX_LINE_LEN)
        begin
            max_line_len_reg <= pwdata[15:0];
        end
    end

    lptc_front #(
        .LINE_COUNT_BITS(LINE_COUNT_BITS)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .page         (page),
        .max_line_len (max_line_len_reg),
        .cmd          (push_cmd),
        .push         (push),
        .full         (full)
    );

    lptc_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .wr_data (push_cmd),
        .full    (full),
        .pop     (pop),
        .rd_data (head_cmd),
        .empty   (empty)
    );

    lptc_back u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .head   (head_cmd),
        .empty  (empty),
        .pop    (pop),
        .script (script)
    );

endmodule

`default_nettype wire
